[rtl/near_field_shelf_filter_top_defines.svh]
// ----------------------------------------------------------------------------
// near_field_shelf_filter_top_defines
// assertion macros shared by the near-field shelf filter rtl
// ----------------------------------------------------------------------------
`ifndef NEAR_FIELD_SHELF_FILTER_TOP_DEFINES_SVH
`define NEAR_FIELD_SHELF_FILTER_TOP_DEFINES_SVH

`ifndef NO_ASSERTIONS
// clocked check, off while reset is low
`define NFSF_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// clocked check, also active during reset
`define NFSF_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define NFSF_ASSERT(label, clk, rst_n, prop, msg)
`define NFSF_ASSERT_ALWAYS(label, clk, prop, msg)
`endif

`endif

[rtl/nfsf_pkg.sv]
// ----------------------------------------------------------------------------
// nfsf_pkg
// widths, register codes and fixed-point helpers of the near-field shelf filter
// ----------------------------------------------------------------------------
`default_nettype none

package nfsf_pkg;

    localparam int SAMPLE_WIDTH = 24;
    localparam int ACC_WIDTH    = 40;
    localparam int COEF_WIDTH   = 32;
    localparam int COEF_FRAC    = 24;
    localparam int ORDER_WIDTH  = 2;
    localparam int CFG_INDEX_WIDTH = 3;

    // full product, rounded product term, and adder width for up to four terms
    localparam int PROD_WIDTH = ACC_WIDTH + COEF_WIDTH;
    localparam int TERM_WIDTH = ACC_WIDTH + COEF_WIDTH - COEF_FRAC + 1;
    localparam int SUM_WIDTH  = TERM_WIDTH + 2;

    localparam logic [ORDER_WIDTH-1:0] ORDER_ONE   = ORDER_WIDTH'(1);
    localparam logic [ORDER_WIDTH-1:0] ORDER_TWO   = ORDER_WIDTH'(2);
    localparam logic [ORDER_WIDTH-1:0] ORDER_THREE = ORDER_WIDTH'(3);

    localparam logic signed [COEF_WIDTH-1:0] GAIN_UNITY =
        COEF_WIDTH'(signed'(1) <<< COEF_FRAC);

    typedef enum logic [CFG_INDEX_WIDTH-1:0] {
        REG_FILTER_ORDER   = 3'd0,
        REG_INPUT_GAIN     = 3'd1,
        REG_ZERO_COEF_ONE  = 3'd2,
        REG_ZERO_COEF_TWO  = 3'd3,
        REG_ZERO_COEF_THREE = 3'd4,
        REG_POLE_COEF_ONE  = 3'd5,
        REG_POLE_COEF_TWO  = 3'd6,
        REG_POLE_COEF_THREE = 3'd7
    } t_reg_idx;

    // x * c / 2^frac, rounded to nearest with ties away from zero
    function automatic logic signed [TERM_WIDTH-1:0] qmul(
        input logic signed [ACC_WIDTH-1:0]  x,
        input logic signed [COEF_WIDTH-1:0] c
    );
        logic signed [PROD_WIDTH-1:0] p;
        logic signed [PROD_WIDTH-1:0] bias;
        logic signed [PROD_WIDTH-1:0] t;
        p    = x * c;
        bias = p[PROD_WIDTH-1] ? PROD_WIDTH'((signed'(1) <<< (COEF_FRAC - 1)) - 1)
                               : PROD_WIDTH'(signed'(1) <<< (COEF_FRAC - 1));
        t    = p + bias;
        return TERM_WIDTH'(t >>> COEF_FRAC);
    endfunction

    // saturate a wide sum to the integrator width
    function automatic logic signed [ACC_WIDTH-1:0] clip_acc(
        input logic signed [SUM_WIDTH-1:0] v
    );
        logic [SUM_WIDTH-ACC_WIDTH:0] top;
        top = v[SUM_WIDTH-1:ACC_WIDTH-1];
        if (top == '0 || top == '1) begin
            return v[ACC_WIDTH-1:0];
        end else if (v[SUM_WIDTH-1]) begin
            return {1'b1, {(ACC_WIDTH-1){1'b0}}};
        end else begin
            return {1'b0, {(ACC_WIDTH-1){1'b1}}};
        end
    endfunction

    // saturate a wide sum to the sample width
    function automatic logic signed [SAMPLE_WIDTH-1:0] clip_out(
        input logic signed [SUM_WIDTH-1:0] v
    );
        logic [SUM_WIDTH-SAMPLE_WIDTH:0] top;
        top = v[SUM_WIDTH-1:SAMPLE_WIDTH-1];
        if (top == '0 || top == '1) begin
            return v[SAMPLE_WIDTH-1:0];
        end else if (v[SUM_WIDTH-1]) begin
            return {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
        end else begin
            return {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
        end
    endfunction

endpackage

`default_nettype wire

[rtl/near_field_shelf_filter_top.sv]
// ----------------------------------------------------------------------------
// near_field_shelf_filter_top
// near-field low-shelf filter of order 1 to 3, integrator form, fixed point
// ----------------------------------------------------------------------------
//
//  channel     direction  handshake                    payload
//  s_axis      in         i_s_axis_tvalid/o_s_axis_tready  tdata = sample_in, tlast = block_end
//  m_axis      out        o_m_axis_tvalid/i_m_axis_tready  tdata = sample_out, tlast = block_end_out
//  cfg         in         i_cfg_valid/o_cfg_ready      i_cfg_index, i_cfg_data
//
//  one item per cycle sustained while m_axis takes results; an accepted item
//  passes the input register, then the result register, before it shows up
//  on m_axis
//  the per-cycle path is set by the integrator loop: a 40x32 multiply of the
//  stored integrators, the section sums and the saturating update
//  reset (i_rst_n low at a clock edge) clears integrators, registers to their
//  defaults and both item registers; no clearing pass is needed
//  an output stall holds the result register; the input register still takes
//  one more item, then s_axis ready drops until the result is taken
//  cfg is always ready; write only while no item is in flight
//
`default_nettype none

`include "near_field_shelf_filter_top_defines.svh"

module near_field_shelf_filter_top (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,

    // input stream
    input  wire logic                                   i_s_axis_tvalid,
    output      logic                                   o_s_axis_tready,
    input  wire logic [nfsf_pkg::SAMPLE_WIDTH-1:0]      i_s_axis_tdata,  // [23:0] sample_in
    input  wire logic                                   i_s_axis_tlast,  // block_end

    // output stream
    output      logic                                   o_m_axis_tvalid,
    input  wire logic                                   i_m_axis_tready,
    output      logic [nfsf_pkg::SAMPLE_WIDTH-1:0]      o_m_axis_tdata,  // [23:0] sample_out
    output      logic                                   o_m_axis_tlast,  // block_end_out

    // register writes
    input  wire logic                                   i_cfg_valid,
    output      logic                                   o_cfg_ready,
    input  wire logic [nfsf_pkg::CFG_INDEX_WIDTH-1:0]   i_cfg_index,
    input  wire logic [nfsf_pkg::COEF_WIDTH-1:0]        i_cfg_data
);

    localparam int AW = nfsf_pkg::ACC_WIDTH;
    localparam int TW = nfsf_pkg::TERM_WIDTH;
    localparam int SW = nfsf_pkg::SUM_WIDTH;

    // configuration registers
    logic [nfsf_pkg::ORDER_WIDTH-1:0]       r_order;
    logic signed [nfsf_pkg::COEF_WIDTH-1:0] r_gain;
    logic signed [nfsf_pkg::COEF_WIDTH-1:0] r_b1, r_b2, r_b3;
    logic signed [nfsf_pkg::COEF_WIDTH-1:0] r_a1, r_a2, r_a3;

    // integrators
    logic signed [AW-1:0] r_z1, r_z2, r_z3;

    // input register
    logic                                      r_in_valid;
    logic signed [nfsf_pkg::SAMPLE_WIDTH-1:0]  r_sample;
    logic                                      r_last;

    // result register
    logic                                      r_out_valid;
    logic        [nfsf_pkg::SAMPLE_WIDTH-1:0]  r_out_data;
    logic                                      r_out_last;

    logic w_adv;      // result register can take a new item this cycle
    logic w_in_fire;  // input item accepted
    logic w_step;     // buffered item is filtered and moves to the result register
    logic w_cfg_fire;
    logic w_two;      // second-order section active
    logic w_three;    // tail section active

    // rounded product terms
    logic signed [TW-1:0] w_pg, w_p1a, w_p1b, w_p2a, w_p2b, w_p3a, w_p3b;
    logic signed [SW-1:0] w_p2a_sel, w_p2b_sel;

    logic signed [AW-1:0] w_y, w_m, w_y3;
    logic signed [SW-1:0] w_res12, w_res3, w_res;
    logic signed [AW-1:0] n_z1, n_z2, n_z3;

    // ------------------------------------------------------------------
    // handshakes
    // ------------------------------------------------------------------
    assign w_adv           = !r_out_valid || i_m_axis_tready;
    assign o_s_axis_tready = w_adv || !r_in_valid;
    assign w_in_fire       = i_s_axis_tvalid && o_s_axis_tready;
    assign w_step          = w_adv && r_in_valid;

    assign o_cfg_ready = 1'b1;
    assign w_cfg_fire  = i_cfg_valid && o_cfg_ready;

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tlast  = r_out_last;

    // ------------------------------------------------------------------
    // datapath: one pass through the active sections
    // ------------------------------------------------------------------
    // order zero and one share the first-order path
    assign w_two   = (r_order == nfsf_pkg::ORDER_TWO) || (r_order == nfsf_pkg::ORDER_THREE);
    assign w_three = (r_order == nfsf_pkg::ORDER_THREE);

    always_comb begin
        // all products work on the stored state and run side by side
        w_pg  = nfsf_pkg::qmul(AW'(r_sample), r_gain);
        w_p1a = nfsf_pkg::qmul(r_z1, r_a1);
        w_p1b = nfsf_pkg::qmul(r_z1, r_b1);
        w_p2a = nfsf_pkg::qmul(r_z2, r_a2);
        w_p2b = nfsf_pkg::qmul(r_z2, r_b2);
        w_p3a = nfsf_pkg::qmul(r_z3, r_a3);
        w_p3b = nfsf_pkg::qmul(r_z3, r_b3);

        // second pole and zero drop out in first-order mode
        w_p2a_sel = w_two ? SW'(w_p2a) : SW'(0);
        w_p2b_sel = w_two ? SW'(w_p2b) : SW'(0);

        // first (or second-order) section
        w_y     = nfsf_pkg::clip_acc(SW'(w_pg) - SW'(w_p1a) - w_p2a_sel);
        w_res12 = SW'(w_y) + SW'(w_p1b) + w_p2b_sel;

        // first-order tail fed by the saturated section output
        w_m    = nfsf_pkg::clip_acc(w_res12);
        w_y3   = nfsf_pkg::clip_acc(SW'(w_m) - SW'(w_p3a));
        w_res3 = SW'(w_y3) + SW'(w_p3b);

        w_res = w_three ? w_res3 : w_res12;

        // integrator updates, second one takes the old first
        n_z1 = nfsf_pkg::clip_acc(SW'(r_z1) + SW'(w_y));
        n_z2 = nfsf_pkg::clip_acc(SW'(r_z2) + SW'(r_z1));
        n_z3 = nfsf_pkg::clip_acc(SW'(r_z3) + SW'(w_y3));
    end

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_order <= nfsf_pkg::ORDER_ONE;
            r_gain  <= nfsf_pkg::GAIN_UNITY;
            r_b1    <= '0;
            r_b2    <= '0;
            r_b3    <= '0;
            r_a1    <= '0;
            r_a2    <= '0;
            r_a3    <= '0;
        end else if (w_cfg_fire) begin
            unique case (nfsf_pkg::t_reg_idx'(i_cfg_index))
                nfsf_pkg::REG_FILTER_ORDER: begin
                    r_order <= i_cfg_data[nfsf_pkg::ORDER_WIDTH-1:0];
                end
                nfsf_pkg::REG_INPUT_GAIN:      r_gain <= i_cfg_data;
                nfsf_pkg::REG_ZERO_COEF_ONE:   r_b1   <= i_cfg_data;
                nfsf_pkg::REG_ZERO_COEF_TWO:   r_b2   <= i_cfg_data;
                nfsf_pkg::REG_ZERO_COEF_THREE: r_b3   <= i_cfg_data;
                nfsf_pkg::REG_POLE_COEF_ONE:   r_a1   <= i_cfg_data;
                nfsf_pkg::REG_POLE_COEF_TWO:   r_a2   <= i_cfg_data;
                nfsf_pkg::REG_POLE_COEF_THREE: r_a3   <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // integrators: only the sections in use move
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_z1 <= '0;
            r_z2 <= '0;
            r_z3 <= '0;
        end else if (w_step) begin
            r_z1 <= n_z1;
            if (w_two) begin
                r_z2 <= n_z2;
            end
            if (w_three) begin
                r_z3 <= n_z3;
            end
        end
    end

    // ------------------------------------------------------------------
    // input and result registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_s_axis_tready) begin
                r_in_valid <= i_s_axis_tvalid;
            end
            if (w_adv) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_fire) begin
            r_sample <= i_s_axis_tdata;
            r_last   <= i_s_axis_tlast;
        end
        if (w_step) begin
            r_out_data <= nfsf_pkg::clip_out(w_res);
            r_out_last <= r_last;
        end
    end

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    // a buffered item that cannot move on stays buffered
    `NFSF_ASSERT(a_in_hold, i_clk, i_rst_n, (r_in_valid && !w_adv) |=> r_in_valid, "buffered item lost")
    // second integrator is frozen outside second and third order
    `NFSF_ASSERT(a_z2_hold, i_clk, i_rst_n, (!(w_step && w_two)) |=> $stable(r_z2), "second integrator moved")
    // tail integrator only moves in third order
    `NFSF_ASSERT(a_z3_hold, i_clk, i_rst_n, (!(w_step && w_three)) |=> $stable(r_z3), "tail integrator moved")
    // a new result always comes from a buffered item
    `NFSF_ASSERT(a_out_src, i_clk, i_rst_n, $rose(r_out_valid) |-> $past(r_in_valid), "result without item")

endmodule

`default_nettype wire
